FILE: rtl/core/mtld_pkg.sv
package mtld_pkg;

    // defaults of the top level parameters
    localparam int CROSSINGS_TO_TRIGGER_DEF = 3;
    localparam int STARTUP_FLOOR_DEF        = 1000;
    localparam int PERIOD_COUNTS_DEF        = 1000;

    // configuration register indexes
    localparam logic [2:0] CFG_SENSITIVITY = 3'd0;
    localparam logic [2:0] CFG_ON_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_STANDBY     = 3'd2;
    localparam logic [2:0] CFG_MIN_DUTY    = 3'd3;
    localparam logic [2:0] CFG_MAX_DUTY    = 3'd4;
    localparam logic [2:0] CFG_FADE_TIME   = 3'd5;
    localparam logic [2:0] CFG_COLOR_TEMP  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // reset values of the configuration registers
    localparam logic [15:0] SENSITIVITY_RST = 16'd100;
    localparam logic [15:0] ON_TIMEOUT_RST  = 16'd5000;
    localparam logic [23:0] STANDBY_RST     = 24'd60000;
    localparam logic [6:0]  MIN_DUTY_RST    = 7'd0;
    localparam logic [6:0]  MAX_DUTY_RST    = 7'd100;
    localparam logic [15:0] FADE_TIME_RST   = 16'd1000;
    localparam logic [6:0]  COLOR_TEMP_RST  = 7'd50;

    localparam logic [6:0]  PCT_FULL       = 7'd100;
    localparam logic [3:0]  COUNT_SAT      = 4'd15;
    localparam logic [9:0]  LEVEL_RST      = 10'd10;

    // ramp direction codes
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    // reciprocal multipliers: x/100 for x < 2^16, y/10000 for y < 2^24 / 1.8
    localparam int MUL_W        = 24;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DIV100_MUL   = 83887;
    localparam int DIV100_SHIFT = 23;
    localparam int DIV10K_MUL   = 13743896;
    localparam int DIV10K_SHIFT = 37;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RELOAD,
        OP_PCT,
        OP_DIV100,
        OP_SQ,
        OP_RANGE,
        OP_DIV10K
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RELOAD,
        ST_SAMPLE,
        ST_TICK,
        ST_PCT,
        ST_DIV,
        ST_SQ,
        ST_RNG,
        ST_FIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    do_sample;
        logic    do_tick;
        t_mul_op op;
        logic    chan;       // 0 cold, 1 warm
        logic    load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic duty_step;
        logic out_free;
    } t_status;

    function automatic logic [6:0] sat_pct(input logic [6:0] v);
        return (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

endpackage

FILE: rtl/core/mtld_in_if.sv
interface mtld_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] sample_value;

    modport source (output valid, func, sample_value, input ready);
    modport sink   (input valid, func, sample_value, output ready);
endinterface

FILE: rtl/core/mtld_out_if.sv
interface mtld_out_if;
    logic              valid;
    logic              ready;
    logic [9:0]        warm_compare;
    logic [9:0]        cold_compare;
    logic [6:0]        duty_percent;
    logic              lamp_on;
    logic signed [1:0] fade_direction;
    logic              standby_due;

    modport source (output valid, warm_compare, cold_compare, duty_percent, lamp_on,
                    fade_direction, standby_due, input ready);
    modport sink   (input valid, warm_compare, cold_compare, duty_percent, lamp_on,
                    fade_direction, standby_due, output ready);
endinterface

FILE: rtl/core/mtld_ctrl.sv
module mtld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mtld_pkg::t_status i_status,
    output mtld_pkg::t_cmd    o_cmd
);

    mtld_pkg::t_state r_state, n_state;
    logic             r_chan, n_chan;

    // state and channel registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtld_pkg::ST_IDLE;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        unique case (r_state)
            mtld_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mtld_pkg::ST_RELOAD;
            end
            mtld_pkg::ST_RELOAD: begin
                n_state = i_status.func ? mtld_pkg::ST_TICK : mtld_pkg::ST_SAMPLE;
            end
            mtld_pkg::ST_SAMPLE: n_state = mtld_pkg::ST_DONE;
            mtld_pkg::ST_TICK: begin
                n_state = i_status.duty_step ? mtld_pkg::ST_PCT : mtld_pkg::ST_DONE;
            end
            mtld_pkg::ST_PCT: n_state = mtld_pkg::ST_DIV;
            mtld_pkg::ST_DIV: n_state = mtld_pkg::ST_SQ;
            mtld_pkg::ST_SQ:  n_state = mtld_pkg::ST_RNG;
            mtld_pkg::ST_RNG: n_state = mtld_pkg::ST_FIN;
            mtld_pkg::ST_FIN: begin
                n_chan  = ~r_chan;
                n_state = r_chan ? mtld_pkg::ST_DONE : mtld_pkg::ST_PCT;
            end
            mtld_pkg::ST_DONE: begin
                if (i_status.out_free) n_state = mtld_pkg::ST_IDLE;
            end
            default: n_state = mtld_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.do_sample = 1'b0;
        o_cmd.do_tick   = 1'b0;
        o_cmd.op        = mtld_pkg::OP_NONE;
        o_cmd.chan      = r_chan;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            mtld_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            mtld_pkg::ST_RELOAD: o_cmd.op        = mtld_pkg::OP_RELOAD;
            mtld_pkg::ST_SAMPLE: o_cmd.do_sample = 1'b1;
            mtld_pkg::ST_TICK:   o_cmd.do_tick   = 1'b1;
            mtld_pkg::ST_PCT:    o_cmd.op        = mtld_pkg::OP_PCT;
            mtld_pkg::ST_DIV:    o_cmd.op        = mtld_pkg::OP_DIV100;
            mtld_pkg::ST_SQ:     o_cmd.op        = mtld_pkg::OP_SQ;
            mtld_pkg::ST_RNG:    o_cmd.op        = mtld_pkg::OP_RANGE;
            mtld_pkg::ST_FIN:    o_cmd.op        = mtld_pkg::OP_DIV10K;
            mtld_pkg::ST_DONE:   o_cmd.load_out  = i_status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/mtld_dp.sv
module mtld_dp #(
    parameter int CROSSINGS_TO_TRIGGER = mtld_pkg::CROSSINGS_TO_TRIGGER_DEF,
    parameter int STARTUP_FLOOR        = mtld_pkg::STARTUP_FLOOR_DEF,
    parameter int PERIOD_COUNTS        = mtld_pkg::PERIOD_COUNTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtld_pkg::t_cmd                i_cmd,
    output mtld_pkg::t_status             o_status,
    input  logic                          i_in_func,
    input  logic [15:0]                   i_in_sample,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [9:0]                    o_warm_compare,
    output logic [9:0]                    o_cold_compare,
    output logic [6:0]                    o_duty_percent,
    output logic                          o_lamp_on,
    output logic signed [1:0]             o_fade_direction,
    output logic                          o_standby_due,
    input  logic                          i_cfg_we,
    input  logic [mtld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CURVE_BASE  = (PERIOD_COUNTS * 10) / 100;
    localparam int CURVE_RANGE = PERIOD_COUNTS - CURVE_BASE;
    localparam int MW          = mtld_pkg::MUL_W;

    // configuration registers
    logic [15:0] r_sens, r_on_to, r_fade_time;
    logic [23:0] r_sb_to;
    logic [6:0]  r_min_duty, r_max_duty, r_ct;

    // controller state
    logic [15:0]       r_floor, n_floor;
    logic              r_lamp, n_lamp;
    logic [3:0]        r_count, n_count;
    logic              r_retrig, n_retrig;
    logic [15:0]       r_on_timer, n_on_timer;
    logic [23:0]       r_sb, n_sb;
    logic [9:0]        r_fd, n_fd;
    logic [6:0]        r_duty, n_duty;
    logic signed [1:0] r_dir, n_dir;
    logic [9:0]        r_warm, r_cold, n_warm, n_cold;
    logic              r_out_valid;

    // working registers
    logic              r_func;
    logic [15:0]       r_sample;
    logic [MW-1:0]     r_acc;
    logic              r_zero;
    logic [9:0]        r_reload;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens      <= mtld_pkg::SENSITIVITY_RST;
            r_on_to     <= mtld_pkg::ON_TIMEOUT_RST;
            r_sb_to     <= mtld_pkg::STANDBY_RST;
            r_min_duty  <= mtld_pkg::MIN_DUTY_RST;
            r_max_duty  <= mtld_pkg::MAX_DUTY_RST;
            r_fade_time <= mtld_pkg::FADE_TIME_RST;
            r_ct        <= mtld_pkg::COLOR_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtld_pkg::CFG_SENSITIVITY: r_sens      <= i_cfg_data[15:0];
                mtld_pkg::CFG_ON_TIMEOUT:  r_on_to     <= i_cfg_data[15:0];
                mtld_pkg::CFG_STANDBY:     r_sb_to     <= i_cfg_data[23:0];
                mtld_pkg::CFG_MIN_DUTY:    r_min_duty  <= i_cfg_data[6:0];
                mtld_pkg::CFG_MAX_DUTY:    r_max_duty  <= i_cfg_data[6:0];
                mtld_pkg::CFG_FADE_TIME:   r_fade_time <= i_cfg_data[15:0];
                mtld_pkg::CFG_COLOR_TEMP:  r_ct        <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sample step: threshold compare and floor average
    logic [16:0] thr;
    logic        hit;
    logic [17:0] floor_sum;
    logic [3:0]  cnt_inc;
    logic        trigger;

    assign thr       = {1'b0, r_floor} + {1'b0, r_sens};
    assign hit       = {1'b0, r_sample} > thr;
    assign floor_sum = ({2'b0, r_floor} << 1) + {2'b0, r_floor} + {2'b0, r_sample};
    assign cnt_inc   = (r_count != mtld_pkg::COUNT_SAT) ? r_count + 4'd1 : r_count;
    assign trigger   = cnt_inc >= 4'(CROSSINGS_TO_TRIGGER);

    // tick step: on-timeout, standby, fade
    logic [15:0] ot_load, ot_next;
    logic        expire, lamp_t;
    logic [23:0] sb_next;
    logic [6:0]  target;
    logic [9:0]  fd_dec;
    logic        fade_go, duty_up, duty_dn;

    assign ot_load = r_retrig ? r_on_to : r_on_timer;
    assign ot_next = (ot_load != 16'd0) ? ot_load - 16'd1 : ot_load;
    assign expire  = (ot_load != 16'd0) && (ot_next == 16'd0);
    assign lamp_t  = expire ? 1'b0 : r_lamp;
    assign sb_next = lamp_t ? r_sb_to : ((r_sb != 24'd0) ? r_sb - 24'd1 : r_sb);
    assign target  = lamp_t ? mtld_pkg::sat_pct(r_max_duty) : mtld_pkg::sat_pct(r_min_duty);
    assign fd_dec  = (r_fd != 10'd0) ? r_fd - 10'd1 : r_fd;
    assign fade_go = (fd_dec == 10'd0);
    assign duty_up = fade_go && (r_duty < target);
    assign duty_dn = fade_go && (r_duty > target);

    // shared multiplier with operand select
    logic [6:0]          ct_sat, pct_sel;
    logic [MW-1:0]       mul_a, mul_b;
    logic [2*MW-1:0]     product;
    logic [MW-1:0]       q100;
    logic [9:0]          q10k;

    assign ct_sat  = mtld_pkg::sat_pct(r_ct);
    assign pct_sel = i_cmd.chan ? 7'(mtld_pkg::PCT_FULL - ct_sat) : ct_sat;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            mtld_pkg::OP_NONE: ;
            mtld_pkg::OP_RELOAD: begin
                mul_a = MW'(r_fade_time);
                mul_b = MW'(mtld_pkg::DIV100_MUL);
            end
            mtld_pkg::OP_PCT: begin
                mul_a = MW'(r_duty);
                mul_b = MW'(pct_sel);
            end
            mtld_pkg::OP_DIV100: begin
                mul_a = r_acc;
                mul_b = MW'(mtld_pkg::DIV100_MUL);
            end
            mtld_pkg::OP_SQ: begin
                mul_a = r_acc;
                mul_b = r_acc;
            end
            mtld_pkg::OP_RANGE: begin
                mul_a = r_acc;
                mul_b = MW'(CURVE_RANGE);
            end
            mtld_pkg::OP_DIV10K: begin
                mul_a = r_acc;
                mul_b = MW'(mtld_pkg::DIV10K_MUL);
            end
            default: ;
        endcase
    end

    assign product = mul_a * mul_b;
    assign q100    = product[mtld_pkg::DIV100_SHIFT +: MW];
    assign q10k    = product[mtld_pkg::DIV10K_SHIFT +: 10];

    // next values of the controller state
    always_comb begin
        n_floor    = r_floor;
        n_lamp     = r_lamp;
        n_count    = r_count;
        n_retrig   = r_retrig;
        n_on_timer = r_on_timer;
        n_sb       = r_sb;
        n_fd       = r_fd;
        n_duty     = r_duty;
        n_dir      = r_dir;
        n_warm     = r_warm;
        n_cold     = r_cold;
        if (i_cmd.do_sample) begin
            if (!r_lamp) begin
                n_floor = floor_sum[17:2];
                if (hit) begin
                    n_count = cnt_inc;
                    if (trigger) begin
                        n_dir    = mtld_pkg::DIR_UP;
                        n_lamp   = 1'b1;
                        n_retrig = 1'b1;
                    end
                end
            end else if (hit) begin
                n_retrig = 1'b1;
            end
        end
        if (i_cmd.do_tick) begin
            n_retrig   = 1'b0;
            n_on_timer = ot_next;
            if (expire) begin
                n_dir   = mtld_pkg::DIR_DOWN;
                n_lamp  = 1'b0;
                n_count = 4'd0;
            end
            n_sb = sb_next;
            n_fd = fade_go ? r_reload : fd_dec;
            if (duty_up) n_duty = r_duty + 7'd1;
            else if (duty_dn) n_duty = r_duty - 7'd1;
        end
        // end of the curve: base plus scaled square, zero part gives zero
        if (i_cmd.op == mtld_pkg::OP_DIV10K) begin
            if (i_cmd.chan) n_warm = r_zero ? 10'd0 : 10'(CURVE_BASE) + q10k;
            else            n_cold = r_zero ? 10'd0 : 10'(CURVE_BASE) + q10k;
        end
    end

    // controller state registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= 16'(STARTUP_FLOOR);
            r_lamp      <= 1'b0;
            r_count     <= 4'd0;
            r_retrig    <= 1'b0;
            r_on_timer  <= 16'd0;
            r_sb        <= 24'd0;
            r_fd        <= 10'd0;
            r_duty      <= 7'd0;
            r_dir       <= mtld_pkg::DIR_NONE;
            r_warm      <= mtld_pkg::LEVEL_RST;
            r_cold      <= mtld_pkg::LEVEL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_floor    <= n_floor;
            r_lamp     <= n_lamp;
            r_count    <= n_count;
            r_retrig   <= n_retrig;
            r_on_timer <= n_on_timer;
            r_sb       <= n_sb;
            r_fd       <= n_fd;
            r_duty     <= n_duty;
            r_dir      <= n_dir;
            r_warm     <= n_warm;
            r_cold     <= n_cold;
            if (i_cmd.load_out)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // item capture and multiplier result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_in_func;
            r_sample <= i_in_sample;
        end
        unique case (i_cmd.op)
            mtld_pkg::OP_NONE: ;
            mtld_pkg::OP_RELOAD: r_reload <= (q100 == '0) ? 10'd1 : q100[9:0];
            mtld_pkg::OP_PCT:    r_acc    <= product[MW-1:0];
            mtld_pkg::OP_DIV100: begin
                r_acc  <= q100;
                r_zero <= (q100 == '0);
            end
            mtld_pkg::OP_SQ:     r_acc    <= product[MW-1:0];
            mtld_pkg::OP_RANGE:  r_acc    <= product[MW-1:0];
            mtld_pkg::OP_DIV10K: ;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_warm_compare   <= r_warm;
            o_cold_compare   <= r_cold;
            o_duty_percent   <= r_duty;
            o_lamp_on        <= r_lamp;
            o_fade_direction <= r_dir;
            o_standby_due    <= !r_lamp && (r_sb == 24'd0);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.func      = r_func;
    assign o_status.duty_step = duty_up || duty_dn;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

FILE: rtl/core/motion_triggered_led_dimmer.sv
// one item at a time: a sample passes the reload, sample and done states, a tick
// the reload, tick and done states; when the duty moves, both compare values are
// redone between tick and done (10 steps of the one shared 24x24 multiplier)
// the result register frees the input side as soon as the result is loaded
// synchronous active-low reset: lamp off, floor at the startup value, duty 0,
// compare values 10, registers at their defaults; standby reads due at once
module motion_triggered_led_dimmer #(
    parameter int CROSSINGS_TO_TRIGGER = mtld_pkg::CROSSINGS_TO_TRIGGER_DEF,
    parameter int STARTUP_FLOOR        = mtld_pkg::STARTUP_FLOOR_DEF,
    parameter int PERIOD_COUNTS        = mtld_pkg::PERIOD_COUNTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mtld_in_if.sink                         i_item,
    mtld_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [mtld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mtld_pkg::t_cmd    cmd;
    mtld_pkg::t_status status;
    logic              in_ready;

    // sequencer
    mtld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_item.ready = in_ready;

    // state, arithmetic and result register
    mtld_dp #(
        .CROSSINGS_TO_TRIGGER (CROSSINGS_TO_TRIGGER),
        .STARTUP_FLOOR        (STARTUP_FLOOR),
        .PERIOD_COUNTS        (PERIOD_COUNTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_func        (i_item.func),
        .i_in_sample      (i_item.sample_value),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_warm_compare   (o_result.warm_compare),
        .o_cold_compare   (o_result.cold_compare),
        .o_duty_percent   (o_result.duty_percent),
        .o_lamp_on        (o_result.lamp_on),
        .o_fade_direction (o_result.fade_direction),
        .o_standby_due    (o_result.standby_due),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

endmodule
